// ===== sv/kmst_pkg.sv =====
package kmst_pkg;

    localparam int MaxEdges   = 256;
    localparam int MaxPoints  = 64;
    localparam int LengthBits = 32;
    localparam int IdxBits    = $clog2(MaxEdges);
    localparam int CntBits    = $clog2(MaxEdges + 1);
    localparam int PtBits     = 6;

    typedef logic [LengthBits-1:0] len_t;
    typedef logic [IdxBits-1:0]    idx_t;
    typedef logic [CntBits-1:0]    cnt_t;
    typedef logic [PtBits-1:0]     pt_t;

    // One stored edge.
    typedef struct packed {
        pt_t  a;
        pt_t  b;
        len_t len;
    } edge_t;

    // Edge store operations requested by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE_IN,
        OP_WRITE_X,
        OP_WRITE_Y
    } mem_op_t;

    // Commands from controller to datapath.
    typedef struct packed {
        mem_op_t op;
        idx_t    addr;
        logic    load_x;
        logic    load_y;
        logic    lab_we;
        pt_t     lab_waddr;
        pt_t     lab_wdata;
        pt_t     lab_raddr;
    } kmst_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        edge_t rd_data;
        edge_t x;
        edge_t y;
        pt_t   lab_rd;
    } kmst_stat_t;

endpackage

// ===== sv/kmst_datapath.sv =====
module kmst_datapath (
    input  logic                 aclk,
    input  kmst_pkg::kmst_cmd_t  cmd,
    input  kmst_pkg::edge_t      wr_edge,
    output kmst_pkg::kmst_stat_t stat
);
    import kmst_pkg::*;

    edge_t mem [MaxEdges];
    edge_t rd_reg;
    edge_t x_reg;
    edge_t y_reg;
    pt_t   label_mem [MaxPoints];
    pt_t   lab_rd_reg;

    // Edge store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_WRITE_IN: mem[cmd.addr] <= wr_edge;
            OP_WRITE_X:  mem[cmd.addr] <= x_reg;
            OP_WRITE_Y:  mem[cmd.addr] <= y_reg;
            OP_READ:     rd_reg <= mem[cmd.addr];
            default: ;
        endcase
    end

    // Two holding registers for comparisons and moves.
    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= rd_reg;
        end
        if (cmd.load_y) begin
            y_reg <= rd_reg;
        end
    end

    // Cluster labels: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.lab_we) begin
            label_mem[cmd.lab_waddr] <= cmd.lab_wdata;
        end
        lab_rd_reg <= label_mem[cmd.lab_raddr];
    end

    always_comb begin
        stat.rd_data = rd_reg;
        stat.x       = x_reg;
        stat.y       = y_reg;
        stat.lab_rd  = lab_rd_reg;
    end

endmodule

// ===== sv/kmst_controller.sv =====
module kmst_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kmst_pkg::pt_t        s_endpoint_a,
    input  kmst_pkg::pt_t        s_endpoint_b,
    input  kmst_pkg::len_t       s_edge_length,
    input  logic                 s_last_edge,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kmst_pkg::pt_t        m_tree_endpoint_a,
    output kmst_pkg::pt_t        m_tree_endpoint_b,
    output kmst_pkg::len_t       m_tree_length,
    output logic                 m_overflow,
    output logic                 m_last_tree_edge,
    output kmst_pkg::kmst_cmd_t  cmd,
    output kmst_pkg::edge_t      wr_edge,
    input  kmst_pkg::kmst_stat_t stat
);
    import kmst_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD,
        S_LBL_INIT,
        S_BUILD,
        S_SIFT_RD,
        S_SIFT_LD,
        S_SIFT,
        S_RD_C1,
        S_RD_C2,
        S_CMP,
        S_PLACE,
        S_EX_RD0,
        S_EX_RDM,
        S_EX_WRM,
        S_MST,
        S_MST_RD,
        S_LAB_A,
        S_LAB_B,
        S_OUT,
        S_RL_RD,
        S_RL_WR,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [6:0] pc_cfg_reg;
    cnt_t cnt_reg;
    logic ovf_reg;
    idx_t start_reg;   // heap build index
    idx_t end_reg;     // last heap index
    idx_t n_reg;       // sift node
    idx_t child_reg;
    logic [IdxBits:0] ch_wide;
    logic extract_reg;
    cnt_t i_reg;
    pt_t  tree_cnt_reg;
    pt_t  p_reg;
    pt_t  lab_a_reg;
    pt_t  old_lab_reg;
    pt_t  new_lab_reg;
    edge_t cur_reg;
    edge_t pend_reg;
    logic pend_valid_reg;
    logic [6:0] pc_eff;
    logic in_range;
    logic pt_last;
    logic mst_end;

    // Effective point count: zero acts as one, capped at the point limit.
    always_comb begin
        pc_eff = pc_cfg_reg;
        if (pc_eff == 7'd0) pc_eff = 7'd1;
        if (pc_eff > 7'(MaxPoints)) pc_eff = 7'(MaxPoints);
    end

    assign in_range  = ({1'b0, s_endpoint_a} < pc_eff) && ({1'b0, s_endpoint_b} < pc_eff);
    assign s_ready   = (state_reg == S_LOAD);
    assign cfg_ready = (state_reg == S_LOAD);
    assign ch_wide   = {n_reg, 1'b1};
    assign pt_last   = ({1'b0, p_reg} == pc_eff - 7'd1);
    assign mst_end   = (i_reg >= cnt_reg) || ({1'b0, tree_cnt_reg} >= pc_eff - 7'd1);

    // Command decode for the datapath.
    always_comb begin
        cmd = '0;
        cmd.op = OP_NONE;
        wr_edge = '{a: s_endpoint_a, b: s_endpoint_b, len: s_edge_length};
        case (state_reg)
            S_LOAD: begin
                if (s_valid && in_range && cnt_reg < cnt_t'(MaxEdges)) begin
                    cmd.op = OP_WRITE_IN;
                    cmd.addr = cnt_reg[IdxBits-1:0];
                end
            end
            S_LBL_INIT: begin
                cmd.lab_we = 1'b1;
                cmd.lab_waddr = p_reg;
                cmd.lab_wdata = p_reg;
            end
            S_SIFT_RD: begin cmd.op = OP_READ; cmd.addr = n_reg; end
            S_SIFT_LD: begin cmd.load_x = 1'b1; end
            S_SIFT: begin
                if (ch_wide <= {1'b0, end_reg}) begin
                    cmd.op = OP_READ;
                    cmd.addr = ch_wide[IdxBits-1:0];
                end
            end
            S_RD_C1: begin
                cmd.load_y = 1'b1;
                if (child_reg < end_reg) begin
                    cmd.op = OP_READ;
                    cmd.addr = child_reg + idx_t'(1);
                end
            end
            S_RD_C2: begin
                if (stat.y.len < stat.rd_data.len) cmd.load_y = 1'b1;
            end
            S_CMP: begin
                if (stat.x.len < stat.y.len) begin
                    cmd.op = OP_WRITE_Y;
                    cmd.addr = n_reg;
                end
            end
            S_PLACE:  begin cmd.op = OP_WRITE_X; cmd.addr = n_reg; end
            S_EX_RD0: begin cmd.op = OP_READ; cmd.addr = '0; end
            S_EX_RDM: begin cmd.op = OP_READ; cmd.addr = end_reg; cmd.load_y = 1'b1; end
            S_EX_WRM: begin cmd.op = OP_WRITE_Y; cmd.addr = end_reg; cmd.load_x = 1'b1; end
            S_MST: begin
                if (!mst_end) begin
                    cmd.op = OP_READ;
                    cmd.addr = i_reg[IdxBits-1:0];
                end
            end
            S_MST_RD: cmd.lab_raddr = stat.rd_data.a;
            S_LAB_A:  cmd.lab_raddr = cur_reg.b;
            S_RL_RD:  cmd.lab_raddr = p_reg;
            S_RL_WR: begin
                if (stat.lab_rd == old_lab_reg) begin
                    cmd.lab_we = 1'b1;
                    cmd.lab_waddr = p_reg;
                    cmd.lab_wdata = new_lab_reg;
                end
            end
            default: ;
        endcase
    end

    // Heapsort and Kruskal sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            pc_cfg_reg <= 7'd64;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (cfg_valid) pc_cfg_reg <= cfg_data;
                    if (s_valid) begin
                        if (in_range) begin
                            if (cnt_reg < cnt_t'(MaxEdges)) cnt_reg <= cnt_reg + cnt_t'(1);
                            else ovf_reg <= 1'b1;
                        end
                        if (s_last_edge) begin
                            p_reg <= '0;
                            state_reg <= S_LBL_INIT;
                        end
                    end
                end
                S_LBL_INIT: begin
                    // Every point starts in its own cluster.
                    if (pt_last) state_reg <= S_BUILD;
                    else p_reg <= p_reg + pt_t'(1);
                end
                S_BUILD: begin
                    i_reg <= '0;
                    tree_cnt_reg <= '0;
                    pend_valid_reg <= 1'b0;
                    if (cnt_reg < cnt_t'(2)) begin
                        state_reg <= S_MST;
                    end else begin
                        end_reg <= idx_t'(cnt_reg - cnt_t'(1));
                        start_reg <= idx_t'((cnt_reg - cnt_t'(1)) >> 1);
                        n_reg <= idx_t'((cnt_reg - cnt_t'(1)) >> 1);
                        extract_reg <= 1'b0;
                        state_reg <= S_SIFT_RD;
                    end
                end
                S_SIFT_RD: state_reg <= S_SIFT_LD;
                S_SIFT_LD: state_reg <= S_SIFT;
                S_SIFT: begin
                    // The sifted value stays in x; stop when the node has no child.
                    if (ch_wide > {1'b0, end_reg}) begin
                        state_reg <= S_PLACE;
                    end else begin
                        child_reg <= ch_wide[IdxBits-1:0];
                        state_reg <= S_RD_C1;
                    end
                end
                S_RD_C1: begin
                    if (child_reg < end_reg) state_reg <= S_RD_C2;
                    else state_reg <= S_CMP;
                end
                S_RD_C2: begin
                    if (stat.y.len < stat.rd_data.len) child_reg <= child_reg + idx_t'(1);
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    // A larger child moves up and the sift continues below it.
                    if (stat.x.len < stat.y.len) begin
                        n_reg <= child_reg;
                        state_reg <= S_SIFT;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    // Sift finished; move to the next node or phase.
                    if (!extract_reg) begin
                        if (start_reg == '0) begin
                            extract_reg <= 1'b1;
                            state_reg <= S_EX_RD0;
                        end else begin
                            start_reg <= start_reg - idx_t'(1);
                            n_reg <= start_reg - idx_t'(1);
                            state_reg <= S_SIFT_RD;
                        end
                    end else begin
                        if (end_reg == '0) state_reg <= S_MST;
                        else state_reg <= S_EX_RD0;
                    end
                end
                S_EX_RD0: state_reg <= S_EX_RDM;
                S_EX_RDM: state_reg <= S_EX_WRM;
                S_EX_WRM: begin
                    // Root goes to the heap end; the old end value sifts from the root.
                    end_reg <= end_reg - idx_t'(1);
                    n_reg <= '0;
                    state_reg <= S_SIFT;
                end
                S_MST: begin
                    if (mst_end) begin
                        if (pend_valid_reg) begin
                            m_tree_endpoint_a <= pend_reg.a;
                            m_tree_endpoint_b <= pend_reg.b;
                            m_tree_length <= pend_reg.len;
                        end else begin
                            m_tree_endpoint_a <= '0;
                            m_tree_endpoint_b <= '0;
                            m_tree_length <= '0;
                        end
                        m_overflow <= ovf_reg;
                        m_last_tree_edge <= 1'b1;
                        m_valid <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_MST_RD;
                    end
                end
                S_MST_RD: begin
                    cur_reg <= stat.rd_data;
                    if ({1'b0, stat.rd_data.a} >= pc_eff || {1'b0, stat.rd_data.b} >= pc_eff) begin
                        i_reg <= i_reg + cnt_t'(1);
                        state_reg <= S_MST;
                    end else begin
                        state_reg <= S_LAB_A;
                    end
                end
                S_LAB_A: begin
                    lab_a_reg <= stat.lab_rd;
                    state_reg <= S_LAB_B;
                end
                S_LAB_B: begin
                    i_reg <= i_reg + cnt_t'(1);
                    if (lab_a_reg != stat.lab_rd) begin
                        // New tree edge; the one held before it is now known not last.
                        old_lab_reg <= stat.lab_rd;
                        new_lab_reg <= lab_a_reg;
                        tree_cnt_reg <= tree_cnt_reg + pt_t'(1);
                        pend_reg <= cur_reg;
                        pend_valid_reg <= 1'b1;
                        p_reg <= '0;
                        if (pend_valid_reg) begin
                            m_tree_endpoint_a <= pend_reg.a;
                            m_tree_endpoint_b <= pend_reg.b;
                            m_tree_length <= pend_reg.len;
                            m_overflow <= ovf_reg;
                            m_last_tree_edge <= 1'b0;
                            m_valid <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_RL_RD;
                        end
                    end else begin
                        state_reg <= S_MST;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= S_RL_RD;
                    end
                end
                S_RL_RD: state_reg <= S_RL_WR;
                S_RL_WR: begin
                    if (pt_last) state_reg <= S_MST;
                    else begin
                        p_reg <= p_reg + pt_t'(1);
                        state_reg <= S_RL_RD;
                    end
                end
                S_FIN: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                    pend_valid_reg <= 1'b0;
                    state_reg <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

// ===== sv/kruskal_mst_heapsort_edges.sv =====
// Edges load at one per cycle; the edge marked last starts a run. A run sets the labels
// one point at a time, then heapsorts: a build sift-down reads its node, an extraction
// swaps root and heap end, each level compares the children and a write places the value.
// The walk reads each edge and its endpoint labels; each tree edge starts a relabel sweep
// over the points. Each result is held until the next tree edge or the end is found, then
// leaves through a registered output; the next edge set is taken once the final result is
// accepted. Reset (aresetn low, synchronous) clears counts and flags; point_count is 64.
module kruskal_mst_heapsort_edges (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [5:0]           s_endpoint_a,
    input  logic [5:0]           s_endpoint_b,
    input  logic [31:0]          s_edge_length,
    input  logic                 s_last_edge,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [5:0]           m_tree_endpoint_a,
    output logic [5:0]           m_tree_endpoint_b,
    output logic [31:0]          m_tree_length,
    output logic                 m_overflow,
    output logic                 m_last_tree_edge
);
    import kmst_pkg::*;

    kmst_cmd_t  cmd;
    kmst_stat_t stat;
    edge_t      wr_edge;

    kmst_controller u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_endpoint_a, .s_endpoint_b,
        .s_edge_length, .s_last_edge, .cfg_valid, .cfg_ready, .cfg_data,
        .m_valid, .m_ready, .m_tree_endpoint_a, .m_tree_endpoint_b,
        .m_tree_length, .m_overflow, .m_last_tree_edge,
        .cmd, .wr_edge, .stat
    );

    kmst_datapath u_dp (
        .aclk, .cmd, .wr_edge, .stat
    );

endmodule
